[rtl/core/flip_pkg.sv]
// Package for the free-list index pool: payload types, codes and constants.
`timescale 1ns / 1ps

package flip_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int CFG_DATA_W = 11;

    // Default pool depth and register reset values.
    localparam int unsigned         DEFAULT_ENTRIES    = 1024;
    localparam logic [COUNT_W-1:0]  POOL_SIZE_RESET    = 11'd1024;

    // Operation carried by an input transaction.
    typedef enum logic [1:0] {
        KIND_FORMAT  = 2'd0,
        KIND_ACQUIRE = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    // Outcome reported with every result.
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_EMPTY       = 2'd1,
        STATUS_BAD_RELEASE = 2'd2,
        STATUS_BAD_SIZE    = 2'd3
    } status_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_POOL_SIZE       = 1'b0,
        REG_SENTINEL_ENABLE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        kind_t              kind;
        logic [INDEX_W-1:0] entry_index;
    } in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] granted_index;
        status_t            status;
        logic [COUNT_W-1:0] free_count;
        logic [COUNT_W-1:0] used_count;
    } out_t;

endpackage

[rtl/core/free_list_index_pool.sv]
// Top level of the free-list index pool: a LIFO free list held in a link memory.
`timescale 1ns / 1ps

// Usage
// The input channel (s_valid, s_ready, s_data) carries one operation per
// transaction: format the pool, acquire an index or release an index. The
// result channel (m_valid, m_ready, m_data) returns exactly one result per
// operation, in order, holding the granted index, a status and the counts.
// The configuration port (cfg_we, cfg_index, cfg_wdata) sets the pool size
// and the sentinel option; both take effect at the next format. They are to be
// written only while the block is idle, which the block itself does not enforce.
// Release, rejected operations and an unused kind give their result in the
// cycle after acceptance. An acquire passes through the pop state, because the
// link of the current top entry has to be read from the link memory, whose
// read is registered, before the top can move. A format walks the link memory
// one entry per cycle. One operation is in flight at a time.
// Reset (aresetn low, synchronous) empties the pool: no index can be acquired
// until a format. The link memory is not cleared; a format writes it.
// When the receiver stalls the result is held in the output register, and a
// further operation is accepted no earlier than the cycle in which it is taken.
module free_list_index_pool #(
    parameter int unsigned ENTRIES = flip_pkg::DEFAULT_ENTRIES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  flip_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output flip_pkg::out_t                  m_data,
    input  logic                            cfg_we,
    input  flip_pkg::cfg_reg_t              cfg_index,
    input  logic [flip_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import flip_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_FMT  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     pool_size_reg;
    logic                   sent_cfg_reg;
    logic [CW-1:0]          active_size_reg, active_size_next;
    logic                   active_sent_reg, active_sent_next;
    logic [CW-1:0]          avail_reg, avail_next;
    logic [AW-1:0]          top_reg, top_next;
    logic [AW-1:0]          fmt_cnt_reg, fmt_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    out_t                   m_data_reg, m_data_next;

    // Link memory and its port signals.
    logic [AW-1:0]          link_mem [ENTRIES];
    logic [AW-1:0]          rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_wdata;

    logic                   s_fire;
    logic [31:0]            idx_w, size_w, active_w, avail_w, cap_w;
    logic [CW-1:0]          size_c;
    logic [AW-1:0]          idx_a;
    logic                   fmt_bad;
    logic                   rel_bad;
    logic                   fmt_last;

    // Builds a result from the granted index, status and count values.
    function automatic out_t make_out(logic [AW-1:0] g, status_t st,
                                      logic [CW-1:0] av, logic [CW-1:0] act);
        logic [31:0] g32;
        logic [31:0] av32;
        logic [31:0] used32;
        out_t        r;
        g32             = 32'(g);
        av32            = 32'(av);
        used32          = 32'(act) - av32;
        r.granted_index = g32[INDEX_W-1:0];
        r.status        = st;
        r.free_count    = av32[COUNT_W-1:0];
        r.used_count    = used32[COUNT_W-1:0];
        return r;
    endfunction

    // A new operation is taken only when idle and the result register is free.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Operand checks, done on 32-bit values so that every depth compares alike.
    assign idx_w    = 32'(s_data.entry_index);
    assign size_w   = 32'(pool_size_reg);
    assign active_w = 32'(active_size_reg);
    assign avail_w  = 32'(avail_reg);
    assign cap_w    = active_w - 32'(active_sent_reg);
    assign size_c   = size_w[CW-1:0];
    assign idx_a    = idx_w[AW-1:0];
    assign fmt_bad  = (size_w > 32'(ENTRIES)) || (sent_cfg_reg && (size_w == 32'd0));
    assign rel_bad  = (idx_w >= active_w) || (idx_w >= 32'(ENTRIES)) ||
                      (active_sent_reg && (idx_w == 32'd0)) || (avail_w >= cap_w);
    assign fmt_last = ((32'(fmt_cnt_reg) + 32'd1) == active_w);

    // Link memory: one write port, one registered read of the current top.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (s_fire) begin
            rd_data_reg <= link_mem[top_reg];
        end
    end

    // Operation sequencer: decides the state update, memory write and result.
    always_comb begin
        state_next       = state_reg;
        active_size_next = active_size_reg;
        active_sent_next = active_sent_reg;
        avail_next       = avail_reg;
        top_next         = top_reg;
        fmt_cnt_next     = fmt_cnt_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        mem_we           = 1'b0;
        mem_waddr        = fmt_cnt_reg;
        mem_wdata        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.kind)
                        KIND_FORMAT: begin
                            if (fmt_bad) begin
                                m_valid_next = 1'b1;
                                m_data_next  = make_out('0, STATUS_BAD_SIZE, avail_reg,
                                                        active_size_reg);
                            end else begin
                                active_size_next = size_c;
                                active_sent_next = sent_cfg_reg;
                                avail_next       = sent_cfg_reg ? size_c - CW'(1) : size_c;
                                top_next         = sent_cfg_reg ? AW'(1) : '0;
                                fmt_cnt_next     = '0;
                                if (size_w == 32'd0) begin
                                    m_valid_next = 1'b1;
                                    m_data_next  = make_out('0, STATUS_OK, '0, '0);
                                end else begin
                                    state_next = ST_FMT;
                                end
                            end
                        end
                        KIND_ACQUIRE: begin
                            if (avail_reg == '0) begin
                                m_valid_next = 1'b1;
                                m_data_next  = make_out('0, STATUS_EMPTY, avail_reg,
                                                        active_size_reg);
                            end else begin
                                state_next = ST_POP;
                            end
                        end
                        KIND_RELEASE: begin
                            m_valid_next = 1'b1;
                            if (rel_bad) begin
                                m_data_next = make_out('0, STATUS_BAD_RELEASE, avail_reg,
                                                       active_size_reg);
                            end else begin
                                mem_we      = 1'b1;
                                mem_waddr   = idx_a;
                                mem_wdata   = top_reg;
                                top_next    = idx_a;
                                avail_next  = avail_reg + CW'(1);
                                m_data_next = make_out('0, STATUS_OK, avail_reg + CW'(1),
                                                       active_size_reg);
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = make_out('0, STATUS_OK, avail_reg,
                                                    active_size_reg);
                        end
                    endcase
                end
            end
            ST_POP: begin
                // The link read at acceptance is now in the read register.
                top_next     = rd_data_reg;
                avail_next   = avail_reg - CW'(1);
                m_valid_next = 1'b1;
                m_data_next  = make_out(top_reg, STATUS_OK, avail_reg - CW'(1),
                                        active_size_reg);
                state_next   = ST_IDLE;
            end
            ST_FMT: begin
                // Thread entry i to entry i + 1; the last entry and the sentinel link to 0.
                mem_we    = 1'b1;
                mem_waddr = fmt_cnt_reg;
                if (fmt_last || (active_sent_reg && (fmt_cnt_reg == '0))) begin
                    mem_wdata = '0;
                end else begin
                    mem_wdata = fmt_cnt_reg + AW'(1);
                end
                if (fmt_last) begin
                    m_valid_next = 1'b1;
                    m_data_next  = make_out('0, STATUS_OK, avail_reg, active_size_reg);
                    state_next   = ST_IDLE;
                end else begin
                    fmt_cnt_next = fmt_cnt_reg + AW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, pool state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pool_size_reg   <= POOL_SIZE_RESET;
            sent_cfg_reg    <= 1'b0;
            active_size_reg <= '0;
            active_sent_reg <= 1'b0;
            avail_reg       <= '0;
            top_reg         <= '0;
            fmt_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            active_size_reg <= active_size_next;
            active_sent_reg <= active_sent_next;
            avail_reg       <= avail_next;
            top_reg         <= top_next;
            fmt_cnt_reg     <= fmt_cnt_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_POOL_SIZE: begin
                        pool_size_reg <= cfg_wdata;
                    end
                    REG_SENTINEL_ENABLE: begin
                        sent_cfg_reg <= cfg_wdata[0];
                    end
                    default: begin
                        pool_size_reg <= pool_size_reg;
                    end
                endcase
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

[rtl/core/flip_checker.sv]
// Port-level checker for the free-list index pool, bound to the top level.
`timescale 1ns / 1ps

module flip_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input flip_pkg::in_t                   s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input flip_pkg::out_t                  m_data
);

    import flip_pkg::*;

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A stalled result stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // A result with a failing status carries index zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     m_valid && (m_data.status != STATUS_OK) |-> m_data.granted_index == '0)
        else $error("index granted with a failing status");

    // An empty pool is reported only when no entry is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     m_valid && (m_data.status == STATUS_EMPTY) |-> m_data.free_count == '0)
        else $error("empty status with free entries");

    // No new operation is taken while a result waits and the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     m_valid && !m_ready |-> !s_ready)
        else $error("operation accepted over a stalled result");

endmodule

bind free_list_index_pool flip_checker u_flip_checker (.*);

[bench/free_list_index_pool_tb.sv]
// Self-checking testbench for the free-list index pool: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module free_list_index_pool_tb;
    import flip_pkg::*;

    localparam int    POOL_ENTRIES    = DEFAULT_ENTRIES;
    localparam int    RANDOM_ITEMS    = 1830;
    localparam int    HOLD_OFF_CYCLES = 300;
    localparam int    WATCHDOG_LIMIT  = 4000;
    localparam int    MAX_REPORTS     = 10;
    localparam kind_t KIND_UNUSED     = kind_t'(2'd3);

    logic                  aclk      = 1'b1;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_we    = 1'b0;
    cfg_reg_t              cfg_index = REG_POOL_SIZE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Operations waiting to be offered and results still owed by the block.
    in_t  pending_ops[$];
    out_t predicted_results[$];

    // Mirror of the pool: link memory, top of the free list and counts.
    logic [COUNT_W-1:0] link_mem [0:POOL_ENTRIES-1];
    logic [COUNT_W-1:0] top_q       = '0;
    logic [COUNT_W-1:0] avail_q     = '0;
    logic [COUNT_W-1:0] size_q      = '0;
    logic               sentinel_q  = 1'b0;
    logic [COUNT_W-1:0] cfg_size    = POOL_SIZE_RESET;
    logic               cfg_sent    = 1'b0;
    int                 held_indices[$];

    // Handshake bookkeeping and traffic shaping.
    logic in_took        = 1'b0;
    logic out_took       = 1'b0;
    int   send_wait      = 0;
    int   recv_wait      = 0;
    int   hold_left      = 0;
    logic hold_off_req   = 1'b0;
    logic hold_off_taken = 1'b0;
    int   gap_max        = 9;
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;

    free_list_index_pool dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Apply one operation to the mirror and work out the result it must give.
    task automatic predict_pool_op(input in_t op, output out_t res);
        logic [COUNT_W-1:0] capacity;
        res        = '0;
        res.status = STATUS_OK;
        case (op.kind)
            KIND_FORMAT: begin
                if (cfg_size > POOL_ENTRIES || (cfg_sent && cfg_size == 0)) begin
                    res.status = STATUS_BAD_SIZE;
                end else begin
                    for (int i = 0; i + 1 < cfg_size; i++) begin
                        link_mem[i] = COUNT_W'(i + 1);
                    end
                    if (cfg_size > 0) begin
                        link_mem[cfg_size - COUNT_W'(1)] = '0;
                    end
                    size_q     = cfg_size;
                    sentinel_q = cfg_sent;
                    avail_q    = cfg_size;
                    top_q      = '0;
                    if (cfg_sent) begin
                        link_mem[0] = '0;
                        top_q       = COUNT_W'(1);
                        avail_q     = cfg_size - COUNT_W'(1);
                    end
                    held_indices.delete();
                end
            end
            KIND_ACQUIRE: begin
                if (avail_q == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.granted_index = top_q[INDEX_W-1:0];
                    held_indices.push_back(int'(top_q));
                    top_q   = link_mem[top_q[INDEX_W-1:0]];
                    avail_q = avail_q - COUNT_W'(1);
                end
            end
            KIND_RELEASE: begin
                capacity = size_q - COUNT_W'(sentinel_q);
                if (op.entry_index >= size_q || (sentinel_q && op.entry_index == 0) ||
                    avail_q >= capacity) begin
                    res.status = STATUS_BAD_RELEASE;
                end else begin
                    link_mem[op.entry_index] = top_q;
                    top_q   = COUNT_W'(op.entry_index);
                    avail_q = avail_q + COUNT_W'(1);
                    for (int k = 0; k < held_indices.size(); k++) begin
                        if (held_indices[k] == int'(op.entry_index)) begin
                            held_indices.delete(k);
                            break;
                        end
                    end
                end
            end
            default: begin
                // The unused kind leaves the pool alone and reports the counts.
            end
        endcase
        res.free_count = avail_q;
        res.used_count = size_q - avail_q;
    endtask

    // Sample both channels, check delivered results and predict accepted operations.
    always @(posedge aclk) begin : pool_monitor
        out_t want_res;
        out_t new_res;
        in_took  <= aresetn && s_valid && s_ready;
        out_took <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: index %0d status %0d free %0d used %0d",
                                 m_data.granted_index, m_data.status,
                                 m_data.free_count, m_data.used_count);
                end else begin
                    want_res = predicted_results.pop_front();
                    if (m_data.granted_index !== want_res.granted_index ||
                        m_data.status !== want_res.status ||
                        m_data.free_count !== want_res.free_count ||
                        m_data.used_count !== want_res.used_count) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"result mismatch: want index %0d status %0d free %0d ",
                                      "used %0d, got index %0d status %0d free %0d used %0d"},
                                     want_res.granted_index, want_res.status,
                                     want_res.free_count, want_res.used_count,
                                     m_data.granted_index, m_data.status,
                                     m_data.free_count, m_data.used_count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_pool_op(s_data, new_res);
                predicted_results.push_back(new_res);
            end
        end
    end

    // Offer queued operations, holding each until it is taken, with a drawn gap after it.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else if (s_valid && !in_took) begin
            // Transaction still outstanding: keep valid and payload as they are.
        end else if (send_wait > 0) begin
            s_valid   <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (pending_ops.size() != 0) begin
            s_data    <= pending_ops.pop_front();
            s_valid   <= 1'b1;
            send_wait <= $urandom_range(0, gap_max);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Take results after a drawn stall; a single long hold-off lets the block back up.
    always @(negedge aclk) begin : result_sink
        int stall;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
        end else if (hold_off_req && !hold_off_taken) begin
            m_ready        <= 1'b0;
            hold_left      <= HOLD_OFF_CYCLES;
            hold_off_taken <= 1'b1;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            stall = out_took ? $urandom_range(0, gap_max) : recv_wait;
            if (stall > 0) begin
                m_ready   <= 1'b0;
                recv_wait <= m_valid ? stall - 1 : stall;
            end else begin
                m_ready   <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    // End the run when neither channel nor the register port has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("free_list_index_pool_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_op(input kind_t kind, input int idx);
        in_t op;
        op.kind        = kind;
        op.entry_index = INDEX_W'(idx);
        pending_ops.push_back(op);
    endtask

    // Both registers are written back to back; only called while the pool is idle.
    task automatic set_pool_config(input logic [COUNT_W-1:0] size, input logic sent);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POOL_SIZE;
        cfg_wdata <= size;
        @(negedge aclk);
        cfg_index <= REG_SENTINEL_ENABLE;
        cfg_wdata <= CFG_DATA_W'(sent);
        @(negedge aclk);
        cfg_we   <= 1'b0;
        cfg_size = size;
        cfg_sent = sent;
    endtask

    task automatic wait_for_idle();
        do
            @(posedge aclk);
        while (pending_ops.size() != 0 || s_valid || predicted_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly acquires and releases of indices currently held, with some noise mixed in.
    task automatic queue_random_ops(input int count, inout int tally);
        int   held_copy[$];
        int   pick;
        int   roll;
        int   edge_idx;
        in_t  op;
        held_copy = held_indices;
        for (int n = 0; n < count; n++) begin
            roll           = $urandom_range(0, 99);
            op.entry_index = INDEX_W'($urandom_range(0, POOL_ENTRIES - 1));
            if (roll < 46) begin
                op.kind = KIND_ACQUIRE;
            end else if (roll < 80) begin
                op.kind = KIND_RELEASE;
                if (held_copy.size() != 0) begin
                    pick           = $urandom_range(0, held_copy.size() - 1);
                    op.entry_index = INDEX_W'(held_copy[pick]);
                    held_copy.delete(pick);
                end
            end else if (roll < 90) begin
                // Releases near the edges: index zero and either side of the pool size.
                op.kind  = KIND_RELEASE;
                edge_idx = int'(size_q) - $urandom_range(0, 1);
                case ($urandom_range(0, 2))
                    0:       op.entry_index = '0;
                    1:       op.entry_index = INDEX_W'(edge_idx < 0 ? 0 : edge_idx);
                    default: op.entry_index = INDEX_W'($urandom_range(0, POOL_ENTRIES - 1));
                endcase
            end else if (roll < 95) begin
                op.kind = KIND_FORMAT;
            end else begin
                op.kind = KIND_UNUSED;
            end
            pending_ops.push_back(op);
            tally++;
        end
    endtask

    initial begin : stimulus
        logic [COUNT_W-1:0] size_pick;
        logic               sent_pick;
        int                 phase;
        int                 done_items;
        int                 batches;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: the empty pool straight out of reset.
        push_op(KIND_ACQUIRE, 0);
        push_op(KIND_RELEASE, 5);
        push_op(KIND_UNUSED, 0);
        wait_for_idle();

        // Directed: small sentinel pool, drained past empty and refilled past full.
        set_pool_config(11'd4, 1'b1);
        push_op(KIND_FORMAT, 0);
        repeat (4) push_op(KIND_ACQUIRE, 0);
        push_op(KIND_RELEASE, 0);
        push_op(KIND_RELEASE, POOL_ENTRIES - 1);
        push_op(KIND_RELEASE, 2);
        push_op(KIND_RELEASE, 1);
        push_op(KIND_RELEASE, 3);
        push_op(KIND_RELEASE, 3);
        push_op(KIND_ACQUIRE, 0);
        push_op(KIND_UNUSED, POOL_ENTRIES - 1);
        wait_for_idle();

        // Directed: rejected sizes, then a legal empty pool.
        set_pool_config(11'd0, 1'b1);
        push_op(KIND_FORMAT, 0);
        wait_for_idle();
        set_pool_config(11'd2047, 1'b0);
        push_op(KIND_FORMAT, 0);
        wait_for_idle();
        set_pool_config(11'd0, 1'b0);
        push_op(KIND_FORMAT, 0);
        push_op(KIND_ACQUIRE, 0);
        wait_for_idle();

        // Random phases, each with its own pool setting.
        phase      = 0;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            case (phase)
                0:       begin size_pick = 11'd1024; sent_pick = 1'b0; end
                1:       begin size_pick = 11'd1024; sent_pick = 1'b1; end
                2:       begin size_pick = 11'd2047; sent_pick = 1'b0; end
                3:       begin size_pick = 11'd1;    sent_pick = 1'b1; end
                4:       begin size_pick = 11'd1;    sent_pick = 1'b0; end
                5:       begin size_pick = 11'd0;    sent_pick = 1'b1; end
                6:       begin size_pick = 11'd0;    sent_pick = 1'b0; end
                7:       begin size_pick = 11'd1025; sent_pick = 1'b1; end
                default: begin
                    if ($urandom_range(0, 99) < 85)
                        size_pick = COUNT_W'($urandom_range(2, 24));
                    else
                        size_pick = COUNT_W'($urandom_range(25, 300));
                    sent_pick = 1'($urandom_range(0, 1));
                end
            endcase
            set_pool_config(size_pick, sent_pick);
            push_op(KIND_FORMAT, $urandom_range(0, POOL_ENTRIES - 1));
            done_items++;
            batches = $urandom_range(2, 3);
            for (int b = 0; b < batches; b++) begin
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
                if (phase == 8 && b == 0) begin
                    // Stall the result side while a long burst keeps arriving.
                    gap_max      = 0;
                    hold_off_req = 1'b1;
                    queue_random_ops(40, done_items);
                end else begin
                    queue_random_ops($urandom_range(20, 40), done_items);
                end
                wait_for_idle();
                // A size change without a format must not touch the live pool.
                if ($urandom_range(0, 4) == 0)
                    set_pool_config(COUNT_W'($urandom_range(1, 30)), cfg_sent);
            end
            phase++;
        end

        while (pending_ops.size() != 0 || s_valid) @(posedge aclk);
        while (predicted_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("free_list_index_pool_tb: PASS");
        end else begin
            $display("free_list_index_pool_tb: FAIL");
        end
        $finish;
    end

endmodule
